// File: design/assert_macros.svh
// Assertion macros used by the subdivider core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define PSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define PSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pss_pkg.sv
// Constants and types for the polyline segment subdivider.
package pss_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int MAX_STEPS   = 32;

    localparam int MINSEG_W = 23;
    localparam int MAXPTS_W = 11;
    localparam int CNT_W    = 11;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 23;

    localparam int MAG_W     = COORD_WIDTH;
    localparam int DIFF_W    = COORD_WIDTH + 1;
    localparam int STEPS_W   = $clog2(MAX_STEPS + 1);
    localparam int REM_W     = STEPS_W;
    localparam int LEN_W     = MINSEG_W + $clog2(MAX_STEPS);
    localparam int MUL_W     = (LEN_W > MAG_W) ? LEN_W : MAG_W;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int D2_W      = 2 * MAG_W + 1;
    localparam int CMP_W     = (PROD_W > D2_W) ? PROD_W : D2_W;
    localparam int DIV_CNT_W = $clog2(MAG_W);

    localparam logic [MINSEG_W-1:0] MIN_SEGMENT_RST = MINSEG_W'(76800);
    localparam logic [MAXPTS_W-1:0] MAX_POINTS_RST  = MAXPTS_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_SEGMENT = CFG_IDX_W'(0),
        REG_MAX_POINTS  = CFG_IDX_W'(1)
    } cfg_reg_t;

endpackage

// File: design/polyline_segment_subdivider_core.sv
// Polyline segment subdivider: splits each polyline segment into evenly spaced points.
//
// A vertex that opens a polyline is taken and gives no points. A later vertex first emits
// the polyline's start vertex (on its first segment), then, while the point limit allows,
// works out the step count with one shared squaring multiplier: states ST_SQ_X, ST_SQ_Y
// and ST_SUM form dx^2 + dy^2 and the first length, then ST_STEP tries one step count at
// a time, up to MAX_STEPS - 2 trials. A shift-subtract divider then splits |dx| and |dy|
// by the step count, after which points leave at one per cycle while the output side
// takes them. The input is not ready while a vertex is in work; the last point of a
// vertex may still wait in the output register while the next vertex is taken. No
// clearing pass after reset.
module polyline_segment_subdivider_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pss_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0]         cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [pss_pkg::COORD_WIDTH-1:0] in_x,
    input  logic signed [pss_pkg::COORD_WIDTH-1:0] in_y,
    input  logic                                   line_start,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [pss_pkg::COORD_WIDTH-1:0] out_x,
    output logic signed [pss_pkg::COORD_WIDTH-1:0] out_y,
    output logic                                   stroke_first,
    output logic                                   run_last
);
    import pss_pkg::*;

`include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SUM,
        ST_STEP,
        ST_DIV,
        ST_EMIT
    } state_t;

    // control
    state_t                 state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   have_prev_reg, have_prev_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [MINSEG_W-1:0]    min_seg_reg, min_seg_next;
    logic [MAXPTS_W-1:0]    max_pts_reg, max_pts_next;

    // datapath
    logic [COORD_WIDTH-1:0] prev_x_reg, prev_x_next;
    logic [COORD_WIDTH-1:0] prev_y_reg, prev_y_next;
    logic [COORD_WIDTH-1:0] cur_x_reg, cur_x_next;
    logic [COORD_WIDTH-1:0] cur_y_reg, cur_y_next;
    logic [MAG_W-1:0]       ax_reg, ax_next;
    logic [MAG_W-1:0]       ay_reg, ay_next;
    logic                   sx_reg, sx_next;
    logic                   sy_reg, sy_next;
    logic                   seg_go_reg, seg_go_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [D2_W-1:0]        d2_reg, d2_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [STEPS_W-1:0]     s_reg, s_next;
    logic [STEPS_W-1:0]     steps_reg, steps_next;
    logic [MAG_W-1:0]       qx_reg, qx_next;
    logic [MAG_W-1:0]       qy_reg, qy_next;
    logic [REM_W-1:0]       rx_reg, rx_next;
    logic [REM_W-1:0]       ry_reg, ry_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [MAG_W-1:0]       qacc_x_reg, qacc_x_next;
    logic [MAG_W-1:0]       qacc_y_reg, qacc_y_next;
    logic [REM_W-1:0]       racc_x_reg, racc_x_next;
    logic [REM_W-1:0]       racc_y_reg, racc_y_next;
    logic [COORD_WIDTH-1:0] out_x_reg, out_x_next;
    logic [COORD_WIDTH-1:0] out_y_reg, out_y_next;
    logic                   first_reg, first_next;
    logic                   last_reg, last_next;

    logic                   in_acc;
    logic                   out_acc;
    logic                   slot_free;
    logic                   out_load;
    logic [MUL_W-1:0]       mul_a;
    logic [DIFF_W-1:0]      dx_in, dy_in;
    logic [CNT_W-1:0]       cnt_eff;
    logic                   seg_go;
    logic [REM_W:0]         trial_x, trial_y;
    logic                   ge_x, ge_y;
    logic [REM_W:0]         rsum_x, rsum_y;
    logic                   wrap_x, wrap_y;
    logic [REM_W-1:0]       rnew_x, rnew_y;
    logic [MAG_W-1:0]       qnew_x, qnew_y;
    logic [DIFF_W-1:0]      delta_x, delta_y;
    logic [DIFF_W-1:0]      pt_x, pt_y;
    logic [CNT_W:0]         cnt_inc;
    logic                   pt_last;

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == ST_IDLE);
    assign in_acc       = in_valid && in_ready;
    assign out_acc      = out_valid_reg && out_ready;
    assign slot_free    = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign stroke_first = first_reg;
    assign run_last     = last_reg;

    always_comb
    begin
        dx_in   = {in_x[COORD_WIDTH-1], in_x} - {prev_x_reg[COORD_WIDTH-1], prev_x_reg};
        dy_in   = {in_y[COORD_WIDTH-1], in_y} - {prev_y_reg[COORD_WIDTH-1], prev_y_reg};
        cnt_eff = (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;
        seg_go  = ({1'b0, cnt_eff} + (CNT_W+1)'(1)) < (CNT_W+1)'(max_pts_reg);

        // shared squaring unit
        unique case (state_reg)
            ST_SQ_X: mul_a = MUL_W'(ax_reg);
            ST_SQ_Y: mul_a = MUL_W'(ay_reg);
            default: mul_a = MUL_W'(len_reg);
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_a);

        // divider bit step
        trial_x = {rx_reg, qx_reg[MAG_W-1]};
        trial_y = {ry_reg, qy_reg[MAG_W-1]};
        ge_x    = trial_x >= {1'b0, steps_reg};
        ge_y    = trial_y >= {1'b0, steps_reg};

        // next point: running quotient and remainder of |d| * s / steps
        rsum_x  = {1'b0, racc_x_reg} + {1'b0, rx_reg};
        rsum_y  = {1'b0, racc_y_reg} + {1'b0, ry_reg};
        wrap_x  = rsum_x >= {1'b0, steps_reg};
        wrap_y  = rsum_y >= {1'b0, steps_reg};
        rnew_x  = wrap_x ? REM_W'(rsum_x - {1'b0, steps_reg}) : REM_W'(rsum_x);
        rnew_y  = wrap_y ? REM_W'(rsum_y - {1'b0, steps_reg}) : REM_W'(rsum_y);
        qnew_x  = qacc_x_reg + qx_reg + MAG_W'(wrap_x);
        qnew_y  = qacc_y_reg + qy_reg + MAG_W'(wrap_y);
        delta_x = sx_reg ? (DIFF_W'(0) - {1'b0, qnew_x}) : {1'b0, qnew_x};
        delta_y = sy_reg ? (DIFF_W'(0) - {1'b0, qnew_y}) : {1'b0, qnew_y};
        pt_x    = {prev_x_reg[COORD_WIDTH-1], prev_x_reg} + delta_x;
        pt_y    = {prev_y_reg[COORD_WIDTH-1], prev_y_reg} + delta_y;
        cnt_inc = {1'b0, cnt_reg} + (CNT_W+1)'(1);
        pt_last = (s_reg == steps_reg) || (cnt_inc >= (CNT_W+1)'(max_pts_reg));

        state_next     = state_reg;
        have_prev_next = have_prev_reg;
        cnt_next       = cnt_reg;
        min_seg_next   = min_seg_reg;
        max_pts_next   = max_pts_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        seg_go_next    = seg_go_reg;
        d2_next        = d2_reg;
        len_next       = len_reg;
        s_next         = s_reg;
        steps_next     = steps_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        div_cnt_next   = div_cnt_reg;
        qacc_x_next    = qacc_x_reg;
        qacc_y_next    = qacc_y_reg;
        racc_x_next    = racc_x_reg;
        racc_y_next    = racc_y_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        out_load       = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_SEGMENT: min_seg_next = cfg_data[MINSEG_W-1:0];
                REG_MAX_POINTS:  max_pts_next = cfg_data[MAXPTS_W-1:0];
                default:         ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (line_start || !have_prev_reg)
                    begin
                        prev_x_next    = in_x;
                        prev_y_next    = in_y;
                        have_prev_next = 1'b1;
                        cnt_next       = '0;
                    end
                    else
                    begin
                        cur_x_next  = in_x;
                        cur_y_next  = in_y;
                        sx_next     = dx_in[DIFF_W-1];
                        sy_next     = dy_in[DIFF_W-1];
                        ax_next     = dx_in[DIFF_W-1] ? MAG_W'(DIFF_W'(0) - dx_in)
                                                      : MAG_W'(dx_in);
                        ay_next     = dy_in[DIFF_W-1] ? MAG_W'(DIFF_W'(0) - dy_in)
                                                      : MAG_W'(dy_in);
                        seg_go_next = seg_go;
                        if (cnt_reg == '0)
                        begin
                            state_next = ST_START;
                        end
                        else if (seg_go)
                        begin
                            state_next = ST_SQ_X;
                        end
                        else
                        begin
                            prev_x_next = in_x;
                            prev_y_next = in_y;
                        end
                    end
                end
            end

            ST_START:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    out_x_next = prev_x_reg;
                    out_y_next = prev_y_reg;
                    first_next = 1'b1;
                    last_next  = !seg_go_reg;
                    cnt_next   = CNT_W'(1);
                    if (seg_go_reg)
                    begin
                        state_next = ST_SQ_X;
                    end
                    else
                    begin
                        prev_x_next = cur_x_reg;
                        prev_y_next = cur_y_reg;
                        state_next  = ST_IDLE;
                    end
                end
            end

            ST_SQ_X:
            begin
                len_next   = LEN_W'({min_seg_reg, 1'b0});
                s_next     = STEPS_W'(2);
                state_next = ST_SQ_Y;
            end

            ST_SQ_Y:
            begin
                d2_next    = D2_W'(prod_reg);
                state_next = ST_SUM;
            end

            ST_SUM:
            begin
                d2_next    = d2_reg + D2_W'(prod_reg);
                len_next   = len_reg + LEN_W'(min_seg_reg);
                state_next = ST_STEP;
            end

            ST_STEP:
            begin
                if ((CMP_W'(prod_reg) >= CMP_W'(d2_reg)) ||
                    (s_reg == STEPS_W'(MAX_STEPS - 1)))
                begin
                    steps_next   = (CMP_W'(prod_reg) >= CMP_W'(d2_reg))
                                   ? s_reg : STEPS_W'(MAX_STEPS);
                    qx_next      = ax_reg;
                    qy_next      = ay_reg;
                    rx_next      = '0;
                    ry_next      = '0;
                    div_cnt_next = '0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    s_next   = s_reg + STEPS_W'(1);
                    len_next = len_reg + LEN_W'(min_seg_reg);
                end
            end

            ST_DIV:
            begin
                qx_next      = {qx_reg[MAG_W-2:0], ge_x};
                qy_next      = {qy_reg[MAG_W-2:0], ge_y};
                rx_next      = ge_x ? REM_W'(trial_x - {1'b0, steps_reg}) : REM_W'(trial_x);
                ry_next      = ge_y ? REM_W'(trial_y - {1'b0, steps_reg}) : REM_W'(trial_y);
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(MAG_W - 1))
                begin
                    qacc_x_next = '0;
                    qacc_y_next = '0;
                    racc_x_next = '0;
                    racc_y_next = '0;
                    s_next      = STEPS_W'(1);
                    state_next  = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_load    = 1'b1;
                    out_x_next  = pt_x[COORD_WIDTH-1:0];
                    out_y_next  = pt_y[COORD_WIDTH-1:0];
                    first_next  = 1'b0;
                    last_next   = pt_last;
                    cnt_next    = cnt_inc[CNT_W-1:0];
                    s_next      = s_reg + STEPS_W'(1);
                    qacc_x_next = qnew_x;
                    qacc_y_next = qnew_y;
                    racc_x_next = rnew_x;
                    racc_y_next = rnew_y;
                    if (pt_last)
                    begin
                        prev_x_next = cur_x_reg;
                        prev_y_next = cur_y_reg;
                        state_next  = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_acc ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            cnt_reg       <= '0;
            min_seg_reg   <= MIN_SEGMENT_RST;
            max_pts_reg   <= MAX_POINTS_RST;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            have_prev_reg <= have_prev_next;
            cnt_reg       <= cnt_next;
            min_seg_reg   <= min_seg_next;
            max_pts_reg   <= max_pts_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        seg_go_reg  <= seg_go_next;
        prod_reg    <= prod_next;
        d2_reg      <= d2_next;
        len_reg     <= len_next;
        s_reg       <= s_next;
        steps_reg   <= steps_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        div_cnt_reg <= div_cnt_next;
        qacc_x_reg  <= qacc_x_next;
        qacc_y_reg  <= qacc_y_next;
        racc_x_reg  <= racc_x_next;
        racc_y_reg  <= racc_y_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
    end

    `PSS_ASSERT_IMP(a_div_rem, state_reg == ST_DIV, (rx_reg < steps_reg) && (ry_reg < steps_reg), "divider remainder out of range")
    `PSS_ASSERT_IMP(a_steps_range, state_reg == ST_EMIT, (steps_reg >= STEPS_W'(2)) && (steps_reg <= STEPS_W'(MAX_STEPS)), "step count out of range")
    `PSS_ASSERT_IMP(a_emit_rem, state_reg == ST_EMIT, (racc_x_reg < steps_reg) && (racc_y_reg < steps_reg), "running remainder out of range")
    `PSS_ASSERT_IMP(a_point_limit, out_load && (state_reg == ST_EMIT), (CNT_W+1)'(cnt_reg) < (CNT_W+1)'(max_pts_reg), "point limit exceeded")
    `PSS_ASSERT_NXT(a_load_shows, out_load, out_valid_reg, "loaded point not presented")

endmodule
